FILE: rtl/core/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants for the line rasterizer
// Field widths, canvas limits and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

    localparam int X_W = 6;
    localparam int Y_W = 5;
    localparam int ERR_W = 9;

    localparam int CW_W = 7;
    localparam int CH_W = 6;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W = 1;

    // largest canvas the compare accepts; larger register values saturate
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 32;
    localparam int LIM_W = 11;

    localparam logic [CW_W-1:0] CANVAS_WIDTH_RST = 7'd60;
    localparam logic [CH_W-1:0] CANVAS_HEIGHT_RST = 6'd30;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'd1;

    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic at_end;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/core/lr_ctrl.sv
// ----------------------------------------------------------------------------
// lr_ctrl: line walk controller
// Two-state sequencer: wait for a segment, then step one point per free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  lr_pkg::t_dp_status  i_status,
    output lr_pkg::t_dp_cmd     o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_s_tready = (r_state == ST_IDLE);
        o_cmd.load = i_s_tvalid && (r_state == ST_IDLE);
        o_cmd.emit = (r_state == ST_WALK) && i_status.out_free;
        n_state    = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (o_cmd.emit && i_status.at_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lr_datapath.sv
// ----------------------------------------------------------------------------
// lr_datapath: Bresenham point stepper
// Holds the walk state, the canvas registers and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_datapath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  lr_pkg::t_dp_cmd                    i_cmd,
    output lr_pkg::t_dp_status                 o_status,
    input  wire  [lr_pkg::X_W-1:0]             i_start_x,
    input  wire  [lr_pkg::Y_W-1:0]             i_start_y,
    input  wire  [lr_pkg::X_W-1:0]             i_end_x,
    input  wire  [lr_pkg::Y_W-1:0]             i_end_y,
    input  wire                                i_cfg_we,
    input  wire  [lr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [lr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire                                i_m_tready,
    output logic                               o_m_tvalid,
    output logic [lr_pkg::X_W-1:0]             o_point_x,
    output logic [lr_pkg::Y_W-1:0]             o_point_y,
    output logic                               o_inside_res,
    output logic                               o_last_point
);

    localparam logic [lr_pkg::LIM_W-1:0] COL_CAP = lr_pkg::LIM_W'(lr_pkg::MAX_COLS);
    localparam logic [lr_pkg::LIM_W-1:0] ROW_CAP = lr_pkg::LIM_W'(lr_pkg::MAX_ROWS);

    // canvas registers
    logic [lr_pkg::CW_W-1:0] r_canvas_w;
    logic [lr_pkg::CH_W-1:0] r_canvas_h;

    // walk state
    logic [lr_pkg::X_W-1:0]          r_cur_x;
    logic [lr_pkg::Y_W-1:0]          r_cur_y;
    logic [lr_pkg::X_W-1:0]          r_tgt_x;
    logic [lr_pkg::Y_W-1:0]          r_tgt_y;
    logic [lr_pkg::X_W-1:0]          r_dx;
    logic [lr_pkg::Y_W-1:0]          r_dy;
    logic                            r_sx_neg;
    logic                            r_sy_neg;
    logic signed [lr_pkg::ERR_W-1:0] r_err;

    // load-time spans
    logic [lr_pkg::X_W:0]            w_diff_x;
    logic [lr_pkg::Y_W:0]            w_diff_y;
    logic [lr_pkg::X_W-1:0]          w_dx;
    logic [lr_pkg::Y_W-1:0]          w_dy;

    // step decision
    logic signed [lr_pkg::ERR_W:0]   w_e2;
    logic signed [lr_pkg::ERR_W:0]   w_dx_ext;
    logic signed [lr_pkg::ERR_W:0]   w_dy_ext;
    logic                            w_step_x;
    logic                            w_step_y;
    logic signed [lr_pkg::ERR_W-1:0] n_err;

    logic [lr_pkg::LIM_W-1:0]        w_wlim;
    logic [lr_pkg::LIM_W-1:0]        w_hlim;
    logic                            w_inside;
    logic                            w_at_end;

    always_comb begin
        w_diff_x = {1'b0, i_end_x} - {1'b0, i_start_x};
        w_diff_y = {1'b0, i_end_y} - {1'b0, i_start_y};
        w_dx = w_diff_x[lr_pkg::X_W] ? lr_pkg::X_W'(-w_diff_x) : w_diff_x[lr_pkg::X_W-1:0];
        w_dy = w_diff_y[lr_pkg::Y_W] ? lr_pkg::Y_W'(-w_diff_y) : w_diff_y[lr_pkg::Y_W-1:0];

        w_e2     = {r_err, 1'b0};
        w_dx_ext = $signed({{(lr_pkg::ERR_W + 1 - lr_pkg::X_W){1'b0}}, r_dx});
        w_dy_ext = $signed({{(lr_pkg::ERR_W + 1 - lr_pkg::Y_W){1'b0}}, r_dy});
        w_step_x = (w_e2 > -w_dy_ext);
        w_step_y = (w_e2 < w_dx_ext);
        n_err = r_err
              - (w_step_x ? lr_pkg::ERR_W'(w_dy_ext) : '0)
              + (w_step_y ? lr_pkg::ERR_W'(w_dx_ext) : '0);

        // saturate canvas size to the supported limits
        w_wlim = ({{(lr_pkg::LIM_W - lr_pkg::CW_W){1'b0}}, r_canvas_w} > COL_CAP)
               ? COL_CAP : {{(lr_pkg::LIM_W - lr_pkg::CW_W){1'b0}}, r_canvas_w};
        w_hlim = ({{(lr_pkg::LIM_W - lr_pkg::CH_W){1'b0}}, r_canvas_h} > ROW_CAP)
               ? ROW_CAP : {{(lr_pkg::LIM_W - lr_pkg::CH_W){1'b0}}, r_canvas_h};
        w_inside = ({{(lr_pkg::LIM_W - lr_pkg::X_W){1'b0}}, r_cur_x} < w_wlim)
                && ({{(lr_pkg::LIM_W - lr_pkg::Y_W){1'b0}}, r_cur_y} < w_hlim);
        w_at_end = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);

        o_status.at_end   = w_at_end;
        o_status.out_free = !o_m_tvalid || i_m_tready;
    end

    // canvas registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= lr_pkg::CANVAS_WIDTH_RST;
            r_canvas_h <= lr_pkg::CANVAS_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lr_pkg::REG_CANVAS_WIDTH:  r_canvas_w <= i_cfg_wdata[lr_pkg::CW_W-1:0];
                lr_pkg::REG_CANVAS_HEIGHT: r_canvas_h <= i_cfg_wdata[lr_pkg::CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x  <= i_start_x;
            r_cur_y  <= i_start_y;
            r_tgt_x  <= i_end_x;
            r_tgt_y  <= i_end_y;
            r_dx     <= w_dx;
            r_dy     <= w_dy;
            r_sx_neg <= !(i_start_x < i_end_x);
            r_sy_neg <= !(i_start_y < i_end_y);
            r_err    <= $signed({{(lr_pkg::ERR_W - lr_pkg::X_W){1'b0}}, w_dx})
                      - $signed({{(lr_pkg::ERR_W - lr_pkg::Y_W){1'b0}}, w_dy});
        end else if (i_cmd.emit && !w_at_end) begin
            if (w_step_x) begin
                r_cur_x <= r_sx_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
            end
            if (w_step_y) begin
                r_cur_y <= r_sy_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
            end
            r_err <= n_err;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_point_x    <= r_cur_x;
            o_point_y    <= r_cur_y;
            o_inside_res <= w_inside;
            o_last_point <= w_at_end;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line walker
// Turns one segment word into the stream of points on the line.
// ----------------------------------------------------------------------------
// A segment word is loaded when it is taken, then the block emits one point
// word per cycle while the output side accepts, from the start point to the
// end point, N = max(|dx|,|dy|)+1 points (1 to 64) per segment. A single
// error-term update produces each point. The input side is ready whenever
// no walk is in progress; the final point may still sit in the output
// register while the next segment is taken. Each point carries a canvas-inside
// flag (tuser) and the end point is marked with tlast. Canvas size registers
// are written through the plain write port; the user must do so only while
// the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer (
    input  wire         i_clk,
    input  wire         i_rst_n,

    // segment input
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] start_x, [10:6] start_y, [16:11] end_x, [21:17] end_y, [23:22] zero
    input  wire  [23:0] s_axis_tdata,

    // point output
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [5:0] point_x, [10:6] point_y, [15:11] zero
    output logic [15:0] m_axis_tdata,
    // [0] inside_res
    output logic        m_axis_tuser,
    // last_point
    output logic        m_axis_tlast,

    // configuration: index 0 canvas_width, index 1 canvas_height
    input  wire         i_cfg_we,
    input  wire  [lr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [lr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    lr_pkg::t_dp_cmd    w_cmd;
    lr_pkg::t_dp_status w_status;

    logic [lr_pkg::X_W-1:0] w_point_x;
    logic [lr_pkg::Y_W-1:0] w_point_y;

    lr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_start_x    (s_axis_tdata[5:0]),
        .i_start_y    (s_axis_tdata[10:6]),
        .i_end_x      (s_axis_tdata[16:11]),
        .i_end_y      (s_axis_tdata[21:17]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_m_tready   (m_axis_tready),
        .o_m_tvalid   (m_axis_tvalid),
        .o_point_x    (w_point_x),
        .o_point_y    (w_point_y),
        .o_inside_res (m_axis_tuser),
        .o_last_point (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, w_point_y, w_point_x};

endmodule

`default_nettype wire

FILE: rtl/core/lr_checker.sv
// ----------------------------------------------------------------------------
// lr_checker: port-level checks for the line rasterizer
// Output stall behavior and input/output sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire        m_axis_tuser,
    input wire        m_axis_tlast
);

    // a stalled point word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("point word changed while stalled");

    // a pending point that is not the end means a walk is still running
    a_busy_mid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input ready in the middle of a line");

    // every accepted segment emits at least one point before the next one
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after a segment was taken");

    // end point taken while idle with no segment offered: the block stays idle
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast && s_axis_tready
         && !s_axis_tvalid) |=> s_axis_tready)
        else $error("block not idle after the end point");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for line_rasterizer
// Drives segment words into the Bresenham walker and checks each point word
// (coordinates, canvas-inside flag, last-point mark) against a predictor in
// the bench. The run covers directed extremes and octants, canvas settings
// from zero to past saturation, and random segments under several idle and
// stall mixes on the input and output streams.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // segment word, start_x in the lowest bits
    typedef struct packed {
        logic [lr_pkg::Y_W-1:0] end_y;
        logic [lr_pkg::X_W-1:0] end_x;
        logic [lr_pkg::Y_W-1:0] start_y;
        logic [lr_pkg::X_W-1:0] start_x;
    } t_line_seg;

    // one visited point as it appears on the output side
    typedef struct packed {
        logic                   last;
        logic                   on_canvas;
        logic [lr_pkg::Y_W-1:0] py;
        logic [lr_pkg::X_W-1:0] px;
    } t_line_pt;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [23:0]                   s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [15:0]                   m_axis_tdata;
    logic                          m_axis_tuser;
    logic                          m_axis_tlast;
    logic                          i_cfg_we = 1'b0;
    logic [lr_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [lr_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    line_rasterizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // segments waiting for the driver, and points the walker still owes us
    t_line_seg segment_backlog[$];
    t_line_pt  pending_points[$];

    int unsigned segments_issued = 0;
    int unsigned segments_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // bench copy of the canvas registers, tracked from the write port
    logic [lr_pkg::CW_W-1:0] canvas_w = lr_pkg::CANVAS_WIDTH_RST;
    logic [lr_pkg::CH_W-1:0] canvas_h = lr_pkg::CANVAS_HEIGHT_RST;

    // set at a rising edge when the segment word on the bus was taken
    logic seg_accepted = 1'b0;

    // Walk one segment with the integer error rule and queue every point.
    // Canvas registers past the maximum canvas saturate before the compare.
    task automatic walk_line(input t_line_seg seg);
        int       x, y, ex, ey, dx, dy, sx, sy, err, e2, wlim, hlim;
        logic     done;
        t_line_pt p;
        x    = seg.start_x;
        y    = seg.start_y;
        ex   = seg.end_x;
        ey   = seg.end_y;
        dx   = (ex > x) ? ex - x : x - ex;
        dy   = (ey > y) ? ey - y : y - ey;
        sx   = (x < ex) ? 1 : -1;
        sy   = (y < ey) ? 1 : -1;
        err  = dx - dy;
        wlim = (canvas_w > lr_pkg::MAX_COLS) ? lr_pkg::MAX_COLS : int'(canvas_w);
        hlim = (canvas_h > lr_pkg::MAX_ROWS) ? lr_pkg::MAX_ROWS : int'(canvas_h);
        done = 1'b0;
        while (!done) begin
            done        = (x == ex) && (y == ey);
            p.px        = x[lr_pkg::X_W-1:0];
            p.py        = y[lr_pkg::Y_W-1:0];
            p.on_canvas = (x < wlim) && (y < hlim);
            p.last      = done;
            pending_points.push_back(p);
            if (!done) begin
                e2 = 2 * err;
                if (e2 > -dy) begin
                    err -= dy;
                    x += sx;
                end
                if (e2 < dx) begin
                    err += dx;
                    y += sy;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: holds a word until it is taken, otherwise pulls the next
    // segment from the backlog unless this cycle is an idle one.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_line_seg nxt;
        logic      nvalid;
        nvalid = s_axis_tvalid && !seg_accepted;
        nxt    = s_axis_tdata[$bits(t_line_seg)-1:0];
        if (!nvalid && segment_backlog.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct) begin
            nxt    = segment_backlog.pop_front();
            nvalid = 1'b1;
        end
        s_axis_tvalid <= nvalid;
        s_axis_tdata  <= {2'b00, nxt};
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: checks each point word taken against the oldest prediction,
    // then predicts any segment taken on the same edge. A point leaving on
    // the edge a segment goes in always belongs to an older segment, so the
    // check goes first.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_line_pt got, want;
        seg_accepted <= s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            canvas_w = lr_pkg::CANVAS_WIDTH_RST;
            canvas_h = lr_pkg::CANVAS_HEIGHT_RST;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tuser,
                       m_axis_tdata[lr_pkg::X_W+lr_pkg::Y_W-1:0]};
                if (pending_points.size() == 0) begin
                    $display("%0t: unexpected point x=%0d y=%0d in=%0b last=%0b",
                             $time, got.px, got.py, got.on_canvas, got.last);
                    mismatch_count++;
                end else begin
                    want = pending_points.pop_front();
                    if (got !== want || m_axis_tdata[15:lr_pkg::X_W+lr_pkg::Y_W] !== '0) begin
                        $display("%0t: point mismatch exp x=%0d y=%0d in=%0b last=%0b",
                                 $time, want.px, want.py, want.on_canvas, want.last);
                        $display("%0t:                got x=%0d y=%0d in=%0b last=%0b pad=%h",
                                 $time, got.px, got.py, got.on_canvas, got.last,
                                 m_axis_tdata[15:lr_pkg::X_W+lr_pkg::Y_W]);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                walk_line(s_axis_tdata[$bits(t_line_seg)-1:0]);
                segments_taken++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lr_pkg::REG_CANVAS_WIDTH:  canvas_w = i_cfg_wdata;
                    lr_pkg::REG_CANVAS_HEIGHT: canvas_h = i_cfg_wdata[lr_pkg::CH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    task automatic queue_coords(input int sx, input int sy, input int ex, input int ey);
        t_line_seg s;
        s.start_x = lr_pkg::X_W'(sx);
        s.start_y = lr_pkg::Y_W'(sy);
        s.end_x   = lr_pkg::X_W'(ex);
        s.end_y   = lr_pkg::Y_W'(ey);
        segment_backlog.push_back(s);
        segments_issued++;
    endtask

    // mostly free segments, with some points, rows and columns mixed in
    task automatic queue_random(input int n);
        int sx, sy, ex, ey;
        repeat (n) begin
            sx = $urandom_range(0, 63);
            sy = $urandom_range(0, 31);
            ex = $urandom_range(0, 63);
            ey = $urandom_range(0, 31);
            case ($urandom_range(0, 9))
                0: begin
                    ex = sx;
                    ey = sy;
                end
                1: ey = sy;
                2: ex = sx;
                default: ;
            endcase
            queue_coords(sx, sy, ex, ey);
        end
    endtask

    // idle means every segment taken and every point back, with spare cycles after
    task automatic wait_drained();
        do @(negedge i_clk);
        while (segments_taken != segments_issued || pending_points.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [lr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lr_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input int sender_pct, input int recv_pct, input int n);
        sender_idle_pct = sender_pct;
        recv_stall_pct  = recv_pct;
        queue_random(n);
        wait_drained();
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset canvas 60x30, no idling
        queue_coords(0, 0, 0, 0);          // single point
        queue_coords(63, 31, 63, 31);      // single point, off canvas
        queue_coords(0, 0, 63, 31);
        queue_coords(63, 31, 0, 0);
        queue_coords(0, 31, 63, 0);
        queue_coords(63, 0, 0, 31);
        queue_coords(0, 5, 63, 5);         // row
        queue_coords(7, 0, 7, 31);         // column
        queue_coords(0, 0, 31, 31);        // exact diagonal
        // all eight octants around one center
        queue_coords(30, 15, 40, 18);
        queue_coords(30, 15, 33, 25);
        queue_coords(30, 15, 27, 25);
        queue_coords(30, 15, 20, 18);
        queue_coords(30, 15, 20, 12);
        queue_coords(30, 15, 27, 5);
        queue_coords(30, 15, 33, 5);
        queue_coords(30, 15, 40, 12);
        wait_drained();

        // zero canvas: nothing inside
        cfg_write(lr_pkg::REG_CANVAS_WIDTH, 7'd0);
        cfg_write(lr_pkg::REG_CANVAS_HEIGHT, 7'd0);
        queue_coords(0, 0, 5, 2);
        queue_coords(63, 31, 60, 31);
        wait_drained();

        // past the limits: saturate to the full canvas (height sees 6 bits)
        cfg_write(lr_pkg::REG_CANVAS_WIDTH, 7'd127);
        cfg_write(lr_pkg::REG_CANVAS_HEIGHT, 7'd127);
        queue_coords(0, 0, 63, 31);
        queue_coords(63, 0, 0, 31);
        wait_drained();

        // smallest legal canvas
        cfg_write(lr_pkg::REG_CANVAS_WIDTH, 7'd1);
        cfg_write(lr_pkg::REG_CANVAS_HEIGHT, 7'd1);
        queue_coords(0, 0, 3, 2);
        queue_coords(2, 1, 0, 0);
        wait_drained();

        // largest legal canvas
        cfg_write(lr_pkg::REG_CANVAS_WIDTH, 7'd64);
        cfg_write(lr_pkg::REG_CANVAS_HEIGHT, 7'd32);
        queue_coords(63, 31, 50, 20);
        wait_drained();

        // random segments, no idling
        run_random(0, 0, 25);

        cfg_write(lr_pkg::REG_CANVAS_WIDTH, 7'($urandom_range(1, 64)));
        cfg_write(lr_pkg::REG_CANVAS_HEIGHT, 7'($urandom_range(1, 32)));
        run_random(87, 0, 25);

        cfg_write(lr_pkg::REG_CANVAS_WIDTH, 7'($urandom_range(1, 64)));
        cfg_write(lr_pkg::REG_CANVAS_HEIGHT, 7'($urandom_range(1, 32)));
        run_random(0, 87, 25);

        // any register value, zero and past saturation included
        cfg_write(lr_pkg::REG_CANVAS_WIDTH, 7'($urandom_range(0, 127)));
        cfg_write(lr_pkg::REG_CANVAS_HEIGHT, 7'($urandom_range(0, 127)));
        run_random(24, 24, 25);

        // back to reset values; sender holds off mid-phase until drained
        cfg_write(lr_pkg::REG_CANVAS_WIDTH, lr_pkg::CANVAS_WIDTH_RST);
        cfg_write(lr_pkg::REG_CANVAS_HEIGHT, 7'(lr_pkg::CANVAS_HEIGHT_RST));
        run_random(0, 0, 15);
        run_random(0, 0, 15);

        // let any stray point show up with the output side open
        recv_stall_pct = 0;
        repeat (80) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS line_rasterizer");
        end else begin
            $display("FAIL line_rasterizer");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #1ms;
        $display("%0t: timeout, %0d points still owed", $time, pending_points.size());
        $display("FAIL line_rasterizer");
        $finish;
    end

endmodule
